// File: src/ffca_pkg.sv
// Package for the first-fit coalescing allocator.
// Holds heap geometry constants, status codes and the sequencer state type.
// No dependencies.
`default_nettype none

package ffca_pkg;

	// Heap geometry defaults
	localparam int DEF_HEAP_BYTES = 4096;
	localparam int ALIGN_BYTES    = 8;
	localparam int ALIGN_SH       = 3;
	localparam int HEADER_BYTES   = 8;
	localparam int HDR_SIZE       = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
	localparam int MIN_SPLIT      = HDR_SIZE * 2;

	// Width of a rounded request (16-bit size plus header and rounding slack)
	localparam int RQW = 17;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_ALLOC_FAIL = 2'd1,
		STAT_FREE_REJ   = 2'd2,
		STAT_FREE_NULL  = 2'd3
	} status_t;

	// Sequencer states
	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_A_CHK,
		S_A_SPLIT,
		S_A_W_NG,
		S_A_W_BLK,
		S_A_W_PREV,
		S_F_G,
		S_F_WALK,
		S_F_WALK_RD,
		S_F_MERGE_P,
		S_F_MERGE_N,
		S_F_NXT,
		S_F_W_G,
		S_F_W_BLK,
		S_F_W_IT,
		S_RESP
	} state_t;

endpackage

`default_nettype wire

// File: src/ffca_hdr_ram.sv
// Header store: one write port, one read port with registered read data.
// Generic memory; no package dependency.
`default_nettype none

module ffca_hdr_ram #(
	parameter int DEPTH = 513,
	parameter int AW    = 10,
	parameter int DW    = 25
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: src/ffca_span_cmp.sv
// Shared adjacency unit: does the block at base end exactly at target?
// Depends on ffca_pkg for the granule shift.
`default_nettype none

module ffca_span_cmp
	import ffca_pkg::*;
#(
	parameter int GW  = 10,
	parameter int SZW = 13
) (
	input  wire logic [GW-1:0]  base_g,
	input  wire logic [SZW-1:0] size,
	input  wire logic [GW-1:0]  target_g,
	output logic                hit
);

	localparam int EW = ((GW + ALIGN_SH) > SZW ? (GW + ALIGN_SH) : SZW) + 1;

	logic [EW-1:0] end_off;
	logic [EW-1:0] tgt_off;

	// byte end of block against byte offset of target
	assign end_off = (EW'(base_g) << ALIGN_SH) + EW'(size);
	assign tgt_off = EW'(target_g) << ALIGN_SH;
	assign hit     = (end_off == tgt_off);

endmodule

`default_nettype wire

// File: src/first_fit_coalescing_allocator.sv
// First-fit coalescing heap allocator, top level.
// Depends on ffca_pkg, ffca_hdr_ram and ffca_span_cmp.
//
// Pulse start while busy is low to issue one allocate or free beat; busy stays
// high until the result, which appears for exactly one cycle with done high and
// cannot be stalled. After reset the header store is cleared, all
// HEAP_BYTES/8+1 entries (513 at the default), with busy high. An allocate
// walks the free list first-fit, then splits the block and writes headers
// back; a free walks the free blocks below the freed address, then merges
// neighbours and writes headers back. All header accesses go through the one
// header memory, which has one write port and one registered read port.
`default_nettype none

module first_fit_coalescing_allocator
	import ffca_pkg::*;
#(
	parameter int HEAP_BYTES = DEF_HEAP_BYTES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        action,
	input  wire logic [15:0] request_size,
	input  wire logic [11:0] block_address,
	output logic             done,
	output logic [1:0]       status,
	output logic [11:0]      result_address,
	output logic [11:0]      free_bytes,
	output logic [11:0]      min_ever_free,
	output logic [31:0]      alloc_count,
	output logic [31:0]      release_count
);

	localparam int GRANULES = HEAP_BYTES / ALIGN_BYTES + 1;
	localparam int END_OFF  = ((HEAP_BYTES - HDR_SIZE) / ALIGN_BYTES) * ALIGN_BYTES;
	localparam int END_G    = END_OFF / ALIGN_BYTES;
	localparam int GW       = $clog2(GRANULES);
	localparam int SZW      = $clog2(HEAP_BYTES + 1);
	localparam int CW       = (SZW > RQW ? SZW : RQW);
	localparam int OFW      = 17;
	localparam int AOW      = GW + ALIGN_SH + 1;
	localparam int HW       = SZW + GW + 2;

	typedef struct packed {
		logic [SZW-1:0] size;
		logic [GW-1:0]  next;
		logic           next_ok;
		logic           used;
	} hdr_t;

	state_t state_q, state_d;

	// memory port
	logic          we;
	logic [GW-1:0] waddr, raddr;
	hdr_t          wdata, rd;
	logic [HW-1:0] rdata_raw;

	// sequencer registers
	logic [GW-1:0]  clr_q;
	logic [RQW-1:0] want_q;
	logic [GW-1:0]  g_q, free_head_q, blk_q, prev_q, it_q, link_q, ng_q;
	logic           prev_head_q, it_head_q, blk_is_it_q, split_q;
	hdr_t           prevhdr_q, blkhdr_q, ithdr_q, ghdr_q;
	logic [SZW-1:0] free_total_q, low_q;
	logic [31:0]    alloc_q, rel_q;
	status_t        status_q;
	logic [11:0]    addr_q;

	// input decode
	logic [RQW-1:0] want_c;
	logic           alloc_go_c;
	logic [OFW-1:0] off_c;
	logic [GW-1:0]  g_c;
	logic           free_bad_c;

	assign want_c = (RQW'(request_size) + RQW'(HDR_SIZE + ALIGN_BYTES - 1))
		& {{(RQW-ALIGN_SH){1'b1}}, {ALIGN_SH{1'b0}}};
	assign alloc_go_c = (request_size != 16'd0) && (CW'(want_c) <= CW'(free_total_q));
	assign off_c = OFW'(block_address) - OFW'(HDR_SIZE);
	assign g_c   = GW'(off_c >> ALIGN_SH);
	assign free_bad_c = (OFW'(block_address) < OFW'(HDR_SIZE))
		|| (off_c[ALIGN_SH-1:0] != '0) || (off_c >= OFW'(END_OFF));

	// walk and split decisions
	logic           a_step_c, a_hit_c, g_live_c, walk_c;
	logic [SZW-1:0] rem_c, blk_final_c, nt_c;
	logic [GW-1:0]  prev_link_c;

	assign a_step_c = (CW'(rd.size) < CW'(want_q)) && rd.next_ok;
	assign a_hit_c  = (blk_q != GW'(END_G)) && (CW'(rd.size) >= CW'(want_q));
	assign g_live_c = rd.used && !rd.next_ok;
	assign walk_c   = (link_q < g_q) && (it_head_q || ithdr_q.next_ok);
	assign rem_c       = SZW'(CW'(blkhdr_q.size) - CW'(want_q));
	assign blk_final_c = split_q ? SZW'(want_q) : blkhdr_q.size;
	assign nt_c        = free_total_q - blk_final_c;
	assign prev_link_c = split_q ? ng_q : blkhdr_q.next;

	// shared adjacency compare, muxed by state
	logic           span_hit;
	logic [GW-1:0]  span_base, span_tgt;
	logic [SZW-1:0] span_size;

	assign span_base = (state_q == S_F_MERGE_P) ? it_q : blk_q;
	assign span_size = (state_q == S_F_MERGE_P) ? ithdr_q.size : blkhdr_q.size;
	assign span_tgt  = (state_q == S_F_MERGE_P) ? g_q : link_q;

	ffca_span_cmp #(.GW(GW), .SZW(SZW)) u_span (
		.base_g   (span_base),
		.size     (span_size),
		.target_g (span_tgt),
		.hit      (span_hit)
	);

	ffca_hdr_ram #(.DEPTH(GRANULES), .AW(GW), .DW(HW)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata_raw)
	);
	assign rd = hdr_t'(rdata_raw);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory port
	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = '0;
		wdata   = '0;
		raddr   = '0;
		unique case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				if (clr_q == '0) begin
					wdata = '{size: SZW'(END_OFF), next: GW'(END_G), next_ok: 1'b1, used: 1'b0};
				end
				if (clr_q == GW'(GRANULES - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					if (!action) begin
						raddr   = free_head_q;
						state_d = alloc_go_c ? S_A_CHK : S_RESP;
					end else if (block_address == 12'd0 || free_bad_c) begin
						state_d = S_RESP;
					end else begin
						raddr   = g_c;
						state_d = S_F_G;
					end
				end
			end
			S_A_CHK: begin
				if (a_step_c) begin
					raddr = rd.next;
				end else if (a_hit_c) begin
					state_d = S_A_SPLIT;
				end else begin
					state_d = S_RESP;
				end
			end
			S_A_SPLIT: state_d = (rem_c > SZW'(MIN_SPLIT)) ? S_A_W_NG : S_A_W_BLK;
			S_A_W_NG: begin
				we      = 1'b1;
				waddr   = ng_q;
				wdata   = '{size: rem_c, next: blkhdr_q.next, next_ok: 1'b1, used: 1'b0};
				state_d = S_A_W_BLK;
			end
			S_A_W_BLK: begin
				we      = 1'b1;
				waddr   = blk_q;
				wdata   = '{size: blk_final_c, next: '0, next_ok: 1'b0, used: 1'b1};
				state_d = prev_head_q ? S_RESP : S_A_W_PREV;
			end
			S_A_W_PREV: begin
				we      = 1'b1;
				waddr   = prev_q;
				wdata   = '{size: prevhdr_q.size, next: prev_link_c, next_ok: 1'b1,
					used: prevhdr_q.used};
				state_d = S_RESP;
			end
			S_F_G:       state_d = g_live_c ? S_F_WALK : S_RESP;
			S_F_WALK: begin
				if (walk_c) begin
					raddr   = link_q;
					state_d = S_F_WALK_RD;
				end else begin
					state_d = S_F_MERGE_P;
				end
			end
			S_F_WALK_RD: state_d = S_F_WALK;
			S_F_MERGE_P: state_d = S_F_MERGE_N;
			S_F_MERGE_N: begin
				if (span_hit && link_q != GW'(END_G)) begin
					raddr   = link_q;
					state_d = S_F_NXT;
				end else begin
					state_d = S_F_W_G;
				end
			end
			S_F_NXT: state_d = S_F_W_G;
			S_F_W_G: begin
				we      = 1'b1;
				waddr   = g_q;
				wdata   = ghdr_q;
				state_d = S_F_W_BLK;
			end
			S_F_W_BLK: begin
				we      = 1'b1;
				waddr   = blk_q;
				wdata   = blkhdr_q;
				state_d = (blk_is_it_q || it_head_q) ? S_RESP : S_F_W_IT;
			end
			S_F_W_IT: begin
				we      = 1'b1;
				waddr   = it_q;
				wdata   = '{size: ithdr_q.size, next: blk_q, next_ok: 1'b1, used: ithdr_q.used};
				state_d = S_RESP;
			end
			S_RESP:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// control and heap bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			free_head_q  <= '0;
			free_total_q <= SZW'(END_OFF);
			low_q        <= SZW'(END_OFF);
			alloc_q      <= '0;
			rel_q        <= '0;
		end else begin
			case (state_q)
				S_CLEAR: clr_q <= clr_q + GW'(1);
				S_A_W_BLK: begin
					free_total_q <= nt_c;
					if (nt_c < low_q) low_q <= nt_c;
					alloc_q <= alloc_q + 32'd1;
					if (prev_head_q) free_head_q <= prev_link_c;
				end
				S_F_G: begin
					if (g_live_c) free_total_q <= free_total_q + rd.size;
				end
				S_F_W_BLK: begin
					rel_q <= rel_q + 32'd1;
					if (!blk_is_it_q && it_head_q) free_head_q <= blk_q;
				end
				default: ;
			endcase
		end
	end

	// working payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				want_q      <= want_c;
				g_q         <= g_c;
				blk_q       <= free_head_q;
				prev_head_q <= 1'b1;
				addr_q      <= '0;
				if (!action) status_q <= STAT_ALLOC_FAIL;
				else if (block_address == 12'd0) status_q <= STAT_FREE_NULL;
				else status_q <= STAT_FREE_REJ;
			end
			S_A_CHK: begin
				if (a_step_c) begin
					prev_q      <= blk_q;
					prev_head_q <= 1'b0;
					prevhdr_q   <= rd;
					blk_q       <= rd.next;
				end else begin
					blkhdr_q <= rd;
				end
			end
			S_A_SPLIT: begin
				split_q <= (rem_c > SZW'(MIN_SPLIT));
				ng_q    <= blk_q + GW'(want_q >> ALIGN_SH);
			end
			S_A_W_BLK: begin
				status_q <= STAT_OK;
				addr_q   <= 12'((AOW'(blk_q) << ALIGN_SH) + AOW'(HDR_SIZE));
			end
			S_F_G: begin
				ghdr_q      <= '{size: rd.size, next: rd.next, next_ok: rd.next_ok, used: 1'b0};
				it_head_q   <= 1'b1;
				link_q      <= free_head_q;
				blk_is_it_q <= 1'b0;
			end
			S_F_WALK: begin
				if (walk_c) begin
					it_q      <= link_q;
					it_head_q <= 1'b0;
				end
			end
			S_F_WALK_RD: begin
				ithdr_q <= rd;
				link_q  <= rd.next;
			end
			S_F_MERGE_P: begin
				if (!it_head_q && span_hit) begin
					blk_q       <= it_q;
					blk_is_it_q <= 1'b1;
					blkhdr_q    <= '{size: ithdr_q.size + ghdr_q.size, next: ithdr_q.next,
						next_ok: ithdr_q.next_ok, used: ithdr_q.used};
				end else begin
					blk_q    <= g_q;
					blkhdr_q <= ghdr_q;
				end
			end
			S_F_MERGE_N: begin
				if (!(span_hit && link_q != GW'(END_G))) begin
					blkhdr_q.next    <= link_q;
					blkhdr_q.next_ok <= 1'b1;
				end
			end
			S_F_NXT: begin
				blkhdr_q.size    <= blkhdr_q.size + rd.size;
				blkhdr_q.next    <= rd.next;
				blkhdr_q.next_ok <= rd.next_ok;
			end
			S_F_W_BLK: status_q <= STAT_OK;
			default: ;
		endcase
	end

	// result ports
	assign busy           = (state_q != S_IDLE);
	assign done           = (state_q == S_RESP);
	assign status         = status_q;
	assign result_address = addr_q;
	assign free_bytes     = 12'(free_total_q);
	assign min_ever_free  = 12'(low_q);
	assign alloc_count    = alloc_q;
	assign release_count  = rel_q;

endmodule

`default_nettype wire
